// File: hw/rtl/smw_pkg.sv
// Shared types and constants for the sliding window median core.
// No dependencies; imported by the cell and top level.
`default_nettype none

package smw_pkg;

   localparam int SAMPLE_W = 32;
   localparam int RESULT_W = 33;
   localparam int CSR_W    = 5;
   // Age field covers the largest supported window depth (64).
   localparam int AGE_W    = 6;

   localparam logic [CSR_W-1:0] CSR_WINDOW_RESET = 5'd5;

   // What one cell shows its neighbors and the scan mux.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic [AGE_W-1:0]           age;
      logic                       occ;      // cell holds a sample
      logic                       gt;       // value above incoming sample, or empty
      logic                       ev_upto;  // eviction at this cell or below
   } smw_tap_type;

   // Boundary taps below cell 0 and above the last cell.
   localparam smw_tap_type TAP_LOW = '{value: '0, age: '0, occ: 1'b0, gt: 1'b0,
                                       ev_upto: 1'b0};
   localparam smw_tap_type TAP_HIGH = '{value: '0, age: '0, occ: 1'b0, gt: 1'b1,
                                        ev_upto: 1'b0};

endpackage

`default_nettype wire

// File: hw/rtl/smw_if.sv
// Valid/ready stream interfaces for the sample and result channels.
// Depends on smw_pkg for payload widths.
`default_nettype none

interface smw_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [smw_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface smw_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [smw_pkg::RESULT_W-1:0]  median_doubled;

   modport source (output valid, output median_doubled, input ready);
   modport sink   (input valid, input median_doubled, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/smw_cell.sv
// One cell of the sorted sample chain: value, age and occupancy.
// Depends on smw_pkg; instantiated in a row by the top level.
`default_nettype none

module smw_cell #(
   parameter int AgeLast = 15
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire logic signed [smw_pkg::SAMPLE_W-1:0] sample,
   input  wire smw_pkg::smw_tap_type                left_tap,
   input  wire smw_pkg::smw_tap_type                right_tap,
   output smw_pkg::smw_tap_type                     tap
);
   import smw_pkg::*;

   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic [AGE_W-1:0]           age_ff, age_in;
   logic                       occ_ff, occ_in;

   logic gt, ev_here, ev_below, from_left, from_right, keep;

   assign gt       = !occ_ff || (value_ff > sample);
   assign ev_here  = occ_ff && (age_ff == AGE_W'(AgeLast));
   assign ev_below = left_tap.ev_upto;

   assign tap = '{value: value_ff, age: age_ff, occ: occ_ff, gt: gt,
                  ev_upto: ev_below | ev_here};

   // net move of each entry: up one if above the insert, down one if above the eviction
   assign from_left  = left_tap.gt && !left_tap.ev_upto;
   assign from_right = !right_tap.gt && (ev_below || ev_here);
   assign keep       = !ev_here && (gt == ev_below);

   always_comb begin
      value_in = value_ff;
      age_in   = age_ff;
      occ_in   = occ_ff;
      if (load) begin
         if (from_left) begin
            value_in = left_tap.value;
            age_in   = left_tap.age + AGE_W'(1);
            occ_in   = left_tap.occ;
         end else if (from_right) begin
            value_in = right_tap.value;
            age_in   = right_tap.age + AGE_W'(1);
            occ_in   = right_tap.occ;
         end else if (keep) begin
            age_in   = age_ff + AGE_W'(1);
         end else begin
            value_in = sample;
            age_in   = '0;
            occ_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_median_core.sv
// Sliding window median: top level with cell chain, rank scan and result register.
// Depends on smw_pkg, smw_if (smw_req_if, smw_rsp_if) and smw_cell.
//  - req_if carries one signed 32-bit sample per beat; rsp_if carries
//    median_doubled, twice the median of the last window_size samples
//    (sum of the two middle values for an even window).
//  - csr_window_size_we/wdata write window_size (reset 5); 0 acts as 1,
//    values above WINDOW_MAX act as WINDOW_MAX. Write only while idle.
//  - The cells keep the last WINDOW_MAX samples sorted, each tagged with
//    its age. A beat inserts the sample and evicts the oldest in the same
//    cycle it is accepted.
//  - Until the window has filled, a beat gives no result and the core is
//    ready again on the next cycle.
//  - Once full, a scan walks the chain one cell per cycle, counting cells
//    younger than the window to find the two middle ranks. The scan stops
//    at the cell of the upper middle rank, then a hold state writes the
//    result register; no new beat is accepted until the core is idle again.
//  - Result sits in an output register; the next sample is accepted while
//    it waits. If a new result is ready before the old one is taken, the
//    core holds it and stops accepting until rsp_if.ready.
//  - Sync reset empties the chain, clears fill count and result valid, sets window_size to 5.
`default_nettype none

module sliding_window_median_core #(
   parameter int WINDOW_MAX = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   smw_req_if.sink                                req_if,
   smw_rsp_if.source                              rsp_if,
   input  wire logic                              csr_window_size_we,
   input  wire logic [smw_pkg::CSR_W-1:0]         csr_window_size_wdata
);
   import smw_pkg::*;

   localparam int CW = $clog2(WINDOW_MAX + 1);               // holds 0..WINDOW_MAX
   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_type;

   state_type                  state_ff, state_in;
   logic [CSR_W-1:0]           csr_window_ff, csr_window_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0]   csr_wide;
   logic [CW-1:0] win;        // effective window
   logic [CW-1:0] fill_clamp, fill_next;
   logic [CW-1:0] rank_lo, rank_hi;
   logic          load, out_free, cell_in_window;

   smw_tap_type   taps [WINDOW_MAX];
   smw_tap_type   cur;

   // ---- window size register and clamp ----
   always_comb begin
      csr_window_in = csr_window_ff;
      if (csr_window_size_we) begin
         csr_window_in = csr_window_size_wdata;
      end
   end

   assign csr_wide = 32'(csr_window_ff);

   always_comb begin
      if (csr_wide == 32'd0) begin
         win = CW'(1);
      end else if (csr_wide > 32'(WINDOW_MAX)) begin
         win = CW'(WINDOW_MAX);
      end else begin
         win = CW'(csr_wide);
      end
   end

   assign rank_lo = (win - CW'(1)) >> 1;
   assign rank_hi = win >> 1;

   // ---- cell chain ----
   assign req_if.ready = (state_ff == ST_IDLE);
   assign load         = req_if.valid && req_if.ready;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      smw_tap_type left_tap, right_tap;
      if (i == 0) begin : g_lo
         assign left_tap = TAP_LOW;
      end else begin : g_lo
         assign left_tap = taps[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_hi
         assign right_tap = TAP_HIGH;
      end else begin : g_hi
         assign right_tap = taps[i+1];
      end
      smw_cell #(.AgeLast(WINDOW_MAX - 1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (load),
         .sample    (req_if.sample),
         .left_tap  (left_tap),
         .right_tap (right_tap),
         .tap       (taps[i])
      );
   end

   // ---- fill tracking ----
   assign fill_clamp = (fill_ff > win) ? win : fill_ff;
   assign fill_next  = (fill_clamp < win) ? fill_clamp + CW'(1) : fill_clamp;

   // ---- scan and result ----
   assign cur            = taps[idx_ff];
   assign cell_in_window = cur.occ && (32'(cur.age) < 32'(win));
   assign out_free       = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               fill_in = fill_next;
               idx_in  = '0;
               cnt_in  = '0;
               if (fill_next == win) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + IW'(1);
            if (cell_in_window) begin
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == rank_lo) begin
                  lo_in = cur.value;
               end
               if (cnt_ff == rank_hi) begin
                  hi_in    = cur.value;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_data_in  = RESULT_W'(lo_ff) + RESULT_W'(hi_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         csr_window_ff <= CSR_WINDOW_RESET;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         csr_window_ff <= csr_window_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.median_doubled = rsp_data_ff;

endmodule

`default_nettype wire
